/* rtl/mixed_radix_index_counter_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the mixed-radix index counter
// Clock clk and synchronous reset rst are taken from the enclosing module.
// ----------------------------------------------------------------------------
`ifndef MIXED_RADIX_INDEX_COUNTER_CORE_MACROS_SVH
`define MIXED_RADIX_INDEX_COUNTER_CORE_MACROS_SVH

// same-cycle implication
`define MRC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mrc_pkg.sv */
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared widths, register indices and control structs.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int NUM_RADIX_REGS = 4;
  localparam int RADIX_W        = 9;
  localparam int DIGIT_W        = 8;
  localparam int POS_W          = 32;
  localparam int DIMS_W         = 3;
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;
  localparam int REG_IDX_W      = 3;

  localparam logic [RADIX_W-1:0] RADIX_MAX = 9'd256;

  localparam logic [REG_IDX_W-1:0] REG_NUM_DIMS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RADIX_0  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RADIX_3  = 3'd4;

  typedef logic [RADIX_W-1:0] radix_t;

  typedef struct packed {
    logic [DIMS_W-1:0]               num_dims;
    radix_t [NUM_RADIX_REGS-1:0]     radix;
    logic                            clear;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [POS_W-1:0]   dividend;
    radix_t             divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [POS_W-1:0]   quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_rsp_t;

endpackage

/* rtl/mrc_cmd_if.sv */
// ----------------------------------------------------------------------------
// mrc_cmd_if
// Command channel: advance or seek, with target position.
// ----------------------------------------------------------------------------
interface mrc_cmd_if import mrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [POS_W-1:0] target;

  modport source (output valid, func, target, input ready);
  modport sink   (input valid, func, target, output ready);
endinterface

/* rtl/mrc_rsp_if.sv */
// ----------------------------------------------------------------------------
// mrc_rsp_if
// Result channel: digits, linear position and status.
// ----------------------------------------------------------------------------
interface mrc_rsp_if import mrc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit_0;
  logic [DIGIT_W-1:0] digit_1;
  logic [DIGIT_W-1:0] digit_2;
  logic [DIGIT_W-1:0] digit_3;
  logic [POS_W-1:0]   position;
  logic               status;

  modport source (output valid, digit_0, digit_1, digit_2, digit_3, position, status,
                  input ready);
  modport sink   (input valid, digit_0, digit_1, digit_2, digit_3, position, status,
                  output ready);
endinterface

/* rtl/mixed_radix_index_counter_core.sv */
// Advance: result registered in the cycle after the transfer; one advance a cycle while results are taken.
// Seek: one pass of the shared 32-step restoring divider per active dimension,
//   each pass peeling one digit; not ready meanwhile.
// A result waiting on the output does not block the next command if taken.
// Reset (synchronous, rst): digits and position zero, num_dims and radices one.
// ----------------------------------------------------------------------------
// mixed_radix_index_counter_core
// Mixed-radix index counter: advance with carry, seek by repeated division.
// ----------------------------------------------------------------------------
`include "mixed_radix_index_counter_core_macros.svh"

module mixed_radix_index_counter_core import mrc_pkg::*; #(
  parameter int MAX_DIMS = 4
) (
  input  logic              clk,
  input  logic              rst,
  mrc_cmd_if.sink           cmd,
  mrc_rsp_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SEEK = 2'b10
  } state_t;

  // zero reads as one, anything past 256 saturates
  function automatic radix_t clamp_radix(radix_t r);
    if (r == '0) return RADIX_W'(1);
    if (r > RADIX_MAX) return RADIX_MAX;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  cfg_t cfg;

  mrc_cfg_regs #(.MAX_DIMS(MAX_DIMS)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // index of the fastest-changing active dimension
  logic [DIM_W-1:0] last_dim;

  always_comb begin
    if (cfg.num_dims == '0)
      last_dim = '0;
    else if (int'(cfg.num_dims) > MAX_DIMS)
      last_dim = DIM_W'(MAX_DIMS - 1);
    else
      last_dim = DIM_W'(int'(cfg.num_dims) - 1);
  end

  radix_t              eff_radix [MAX_DIMS];
  logic [MAX_DIMS-1:0] dim_act;

  // dimensions with no radix register are fixed at radix one
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
    if (d < NUM_RADIX_REGS) begin : g_reg
      assign eff_radix[d] = clamp_radix(cfg.radix[d]);
    end else begin : g_fixed
      assign eff_radix[d] = RADIX_W'(1);
    end
    assign dim_act[d] = (DIM_W'(d) <= last_dim);
  end

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  state_t             state;
  logic [DIGIT_W-1:0] digits  [MAX_DIMS];
  logic [DIGIT_W-1:0] scratch [MAX_DIMS];
  logic [POS_W-1:0]   position;
  logic [POS_W-1:0]   tgt;
  logic [DIM_W-1:0]   dim_idx;
  logic               rsp_valid;

  logic accept;
  assign cmd.ready = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = cmd.valid && cmd.ready;

  // --------------------------------------------------------------------------
  // advance: carry ripples from the last active dimension toward dimension 0.
  // The final position is the one where every active digit sits at radix - 1.
  // --------------------------------------------------------------------------
  logic [DIGIT_W-1:0] adv_digits [MAX_DIMS];
  logic               adv_final;

  always_comb begin
    logic c;
    logic at_max;
    c = 1'b1;
    for (int k = MAX_DIMS - 1; k >= 0; k--) begin
      at_max        = ({1'b0, digits[k]} == (eff_radix[k] - RADIX_W'(1)));
      adv_digits[k] = digits[k];
      if (dim_act[k] && c)
        adv_digits[k] = at_max ? '0 : digits[k] + DIGIT_W'(1);
      c = c & (at_max | ~dim_act[k]);
    end
    adv_final = c;
  end

  // --------------------------------------------------------------------------
  // seek: divide by each radix in turn from the last active dimension; the
  // remainder is that digit, the quotient goes on. A nonzero quotient left
  // after dimension 0 means the target is past the total length.
  // --------------------------------------------------------------------------
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic [DIM_W-1:0] div_dim;
  logic             seek_step;
  logic             seek_done;
  logic             seek_ok;

  assign seek_step = (state == S_SEEK) && div_rsp.done;
  assign seek_done = seek_step && (dim_idx == '0);
  assign seek_ok   = seek_done && (div_rsp.quotient == '0);
  assign div_dim   = accept ? last_dim : dim_idx - DIM_W'(1);

  assign div_req.start    = (accept && cmd.func) || (seek_step && dim_idx != '0);
  assign div_req.dividend = accept ? cmd.target : div_rsp.quotient;
  assign div_req.divisor  = eff_radix[div_dim];

  mrc_div_unit u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic [DIGIT_W-1:0] seek_digits [MAX_DIMS];

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_seek
    if (d == 0) begin : g_first
      assign seek_digits[d] = div_rsp.remainder;
    end else begin : g_rest
      assign seek_digits[d] = dim_act[d] ? scratch[d] : '0;
    end
  end

  // --------------------------------------------------------------------------
  // result selection
  // --------------------------------------------------------------------------
  logic               res_load;
  logic               res_status;
  logic               commit;
  logic [DIGIT_W-1:0] nd [MAX_DIMS];
  logic [POS_W-1:0]   np;

  assign res_load   = (accept && !cmd.func) || seek_done;
  assign res_status = seek_done ? (div_rsp.quotient != '0) : adv_final;
  assign commit     = (accept && !cmd.func && !adv_final) || seek_ok;

  always_comb begin
    for (int k = 0; k < MAX_DIMS; k++) begin
      if (accept && !cmd.func && !adv_final) nd[k] = adv_digits[k];
      else if (seek_ok)                      nd[k] = seek_digits[k];
      else                                   nd[k] = digits[k];
    end
    if (accept && !cmd.func && !adv_final) np = position + POS_W'(1);
    else if (seek_ok)                      np = tgt;
    else                                   np = position;
  end

  logic [DIGIT_W-1:0] out_dig [NUM_RADIX_REGS];

  for (genvar j = 0; j < NUM_RADIX_REGS; j++) begin : g_out
    if (j < MAX_DIMS) begin : g_live
      assign out_dig[j] = dim_act[j] ? nd[j] : '0;
    end else begin : g_none
      assign out_dig[j] = '0;
    end
  end

  // --------------------------------------------------------------------------
  // sequencer and counter state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      position  <= '0;
      for (int k = 0; k < MAX_DIMS; k++) digits[k] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && cmd.func) state <= S_SEEK;
        end
        S_SEEK: begin
          if (seek_done) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (res_load)       rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;

      if (cfg.clear) begin
        position <= '0;
        for (int k = 0; k < MAX_DIMS; k++) digits[k] <= '0;
      end else if (commit) begin
        position <= np;
        for (int k = 0; k < MAX_DIMS; k++) digits[k] <= nd[k];
      end
    end
  end

  // seek working registers and result payload
  logic [DIGIT_W-1:0] rsp_dig [NUM_RADIX_REGS];
  logic [POS_W-1:0]   rsp_pos;
  logic               rsp_st;

  always_ff @(posedge clk) begin
    if (accept && cmd.func) begin
      tgt     <= cmd.target;
      dim_idx <= last_dim;
    end else if (seek_step && dim_idx != '0) begin
      dim_idx <= dim_idx - DIM_W'(1);
    end
    if (seek_step) scratch[dim_idx] <= div_rsp.remainder;
    if (res_load) begin
      for (int j = 0; j < NUM_RADIX_REGS; j++) rsp_dig[j] <= out_dig[j];
      rsp_pos <= np;
      rsp_st  <= res_status;
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.digit_0  = rsp_dig[0];
  assign rsp.digit_1  = rsp_dig[1];
  assign rsp.digit_2  = rsp_dig[2];
  assign rsp.digit_3  = rsp_dig[3];
  assign rsp.position = rsp_pos;
  assign rsp.status   = rsp_st;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `MRC_ASSERT_IMPL(a_no_ready_in_seek, state == S_SEEK, !cmd.ready, "ready during seek")
  `MRC_ASSERT_IMPL(a_div_done_in_seek, div_rsp.done, state == S_SEEK, "divider done out of seek")
  `MRC_ASSERT_IMPL(a_digit0_in_range, 1'b1, 9'(digits[0]) < eff_radix[0], "digit 0 past radix")
  `MRC_ASSERT_NEXT(a_advance_result, accept && !cmd.func, rsp.valid, "advance gave no result")

endmodule

/* rtl/mrc_div_unit.sv */
// ----------------------------------------------------------------------------
// mrc_div_unit
// Restoring divider, 32-bit dividend by 9-bit radix, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mrc_div_unit import mrc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(POS_W);

  logic               busy;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [POS_W-1:0]   quot;
  logic [DIGIT_W-1:0] rem;
  radix_t             dvs;

  logic [RADIX_W-1:0] shifted;
  logic [RADIX_W-1:0] diff;
  logic               ge;

  // remainder stays below the divisor (at most 256), so 8 bits hold it
  assign shifted = {rem, quot[POS_W-1]};
  assign ge      = (shifted >= dvs);
  assign diff    = shifted - dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(POS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.dividend;
      rem  <= '0;
      dvs  <= req.divisor;
    end else if (busy) begin
      quot <= {quot[POS_W-2:0], ge};
      rem  <= ge ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quot;
  assign rsp.remainder = rem;

endmodule

/* rtl/mrc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mrc_cfg_regs
// APB register file: dimension count and per-dimension radix.
// ----------------------------------------------------------------------------
module mrc_cfg_regs import mrc_pkg::*; #(
  parameter int MAX_DIMS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [DIMS_W-1:0]    num_dims;
  radix_t               radix [NUM_RADIX_REGS];
  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims <= DIMS_W'(1);
      for (int i = 0; i < NUM_RADIX_REGS; i++) radix[i] <= RADIX_W'(1);
    end else if (wr) begin
      if (idx == REG_NUM_DIMS) num_dims <= pwdata[DIMS_W-1:0];
      // radix registers past MAX_DIMS hold their reset value
      for (int i = 0; i < NUM_RADIX_REGS; i++) begin
        if (idx == REG_IDX_W'(int'(REG_RADIX_0) + i) && i < MAX_DIMS)
          radix[i] <= pwdata[RADIX_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_NUM_DIMS:           prdata = DATA_W'(num_dims);
      REG_RADIX_0:            prdata = DATA_W'(radix[0]);
      REG_RADIX_0 + 3'd1:     prdata = DATA_W'(radix[1]);
      REG_RADIX_0 + 3'd2:     prdata = DATA_W'(radix[2]);
      REG_RADIX_3:            prdata = DATA_W'(radix[3]);
      default:                prdata = '0;
    endcase
  end

  always_comb begin
    cfg.num_dims = num_dims;
    for (int i = 0; i < NUM_RADIX_REGS; i++) cfg.radix[i] = radix[i];
    // any write to a listed register resets the walk
    cfg.clear = wr && (idx <= REG_RADIX_3);
  end

endmodule
